[rtl/assert_macros.svh]
// Assertion macros shared by the stack slot allocator RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define SSA_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SSA_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SSA_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssa_pkg.sv]
// Shared constants, word types and codes of the stack slot allocator.
// No dependencies.
package ssa_pkg;

    localparam int POOL_SIZE      = 16;
    localparam int SLOT_SIZE_LOG2 = 12;
    localparam int ADDR_W         = 32;
    localparam int PTR_W          = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int QUO_W          = ADDR_W - SLOT_SIZE_LOG2;
    localparam int STATUS_W       = 2;
    localparam int KIND_W         = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

    localparam logic [KIND_W-1:0] JOB_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] JOB_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] JOB_BAD   = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] stack_top_in;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0]   stack_top_out;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PTR_W-1:0]  idx;
    } t_job;

endpackage

[rtl/ssa_front.sv]
// Front end: accepts request words and classifies them into jobs.
// Depends on ssa_pkg.
module ssa_front (
    input  logic                   i_valid,
    output logic                   o_stall,
    input  ssa_pkg::t_in_word      i_in,
    input  logic [ssa_pkg::ADDR_W-1:0] i_pool_base,
    input  logic                   i_full,
    output logic                   o_push,
    output ssa_pkg::t_job          o_job
);
    import ssa_pkg::*;

    localparam logic [QUO_W-1:0] POOL_SIZE_Q = QUO_W'(POOL_SIZE);

    logic [ADDR_W-1:0]         offset;
    logic [QUO_W-1:0]          quo;
    logic [SLOT_SIZE_LOG2-1:0] rem;
    logic                      hit;

    // Map a top address back to its slot: offset must be a whole number of
    // slots between one and the pool size.
    always_comb begin
        offset = i_in.stack_top_in - i_pool_base;
        quo    = offset[ADDR_W-1:SLOT_SIZE_LOG2];
        rem    = offset[SLOT_SIZE_LOG2-1:0];
        hit    = (rem == '0) && (quo != '0) && (quo <= POOL_SIZE_Q);

        o_job.idx = PTR_W'(quo - QUO_W'(1));
        if (i_in.cmd == CMD_ALLOC) begin
            o_job.kind = JOB_ALLOC;
        end else if (hit) begin
            o_job.kind = JOB_FREE;
        end else begin
            o_job.kind = JOB_BAD;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

[rtl/ssa_queue.sv]
// Short job queue between front and back end.
// Depends on ssa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssa_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output ssa_pkg::t_job o_job,
    input  logic          i_pop
);
    import ssa_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `SSA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

[rtl/ssa_back.sv]
// Back end: holds the used bits and scan pointer, executes jobs, drives results.
// Depends on ssa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssa_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ssa_pkg::ADDR_W-1:0] i_pool_base,
    input  logic                       i_q_valid,
    input  ssa_pkg::t_job              i_q_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ssa_pkg::t_out_word         o_out
);
    import ssa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(POOL_SIZE - 1);

    logic                 r_state;
    logic                 n_state;
    t_job                 r_job;
    t_job                 n_job;
    logic [POOL_SIZE-1:0] r_used;
    logic [POOL_SIZE-1:0] n_used;
    logic [PTR_W-1:0]     r_ptr;
    logic [PTR_W-1:0]     n_ptr;
    logic [PTR_W-1:0]     r_cnt;
    logic [PTR_W-1:0]     n_cnt;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_word            r_out;
    t_out_word            n_out;
    logic                 out_free;
    logic                 alloc_hit;
    logic [PTR_W-1:0]     ptr_inc;
    logic [ADDR_W-1:0]    slot_off;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign alloc_hit = (r_state == S_BUSY) && out_free && (r_job.kind == JOB_ALLOC)
                       && !r_used[r_ptr];
    assign ptr_inc   = (r_ptr == LAST_IDX) ? '0 : r_ptr + PTR_W'(1);
    assign slot_off  = ADDR_W'({1'b0, r_ptr} + (PTR_W + 1)'(1)) << SLOT_SIZE_LOG2;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_used      = r_used;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_job   = i_q_job;
                    n_cnt   = '0;
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                // Hold the job while the previous result is still waiting.
                if (out_free) begin
                    unique case (r_job.kind)
                        JOB_ALLOC: begin
                            if (!r_used[r_ptr]) begin
                                n_used[r_ptr]       = 1'b1;
                                n_out.stack_top_out = i_pool_base + slot_off;
                                n_out.status        = ST_OK;
                                n_out_valid         = 1'b1;
                                n_state             = S_IDLE;
                            end else if (r_cnt == LAST_IDX) begin
                                // Full pool: the pointer lands back on its start.
                                n_ptr               = ptr_inc;
                                n_out.stack_top_out = '0;
                                n_out.status        = ST_FULL;
                                n_out_valid         = 1'b1;
                                n_state             = S_IDLE;
                            end else begin
                                n_ptr = ptr_inc;
                                n_cnt = r_cnt + PTR_W'(1);
                            end
                        end
                        JOB_FREE: begin
                            n_used[r_job.idx]   = 1'b0;
                            n_out.stack_top_out = '0;
                            n_out.status        = ST_OK;
                            n_out_valid         = 1'b1;
                            n_state             = S_IDLE;
                        end
                        default: begin
                            n_out.stack_top_out = '0;
                            n_out.status        = ST_BAD_ADDR;
                            n_out_valid         = 1'b1;
                            n_state             = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    `SSA_NEXT(a_alloc_marks, i_clk, i_rst_n, alloc_hit, r_used[$past(r_ptr)], "allocated slot not marked used")
    `SSA_ASSERT(a_ptr_range, i_clk, i_rst_n, r_ptr <= LAST_IDX, "scan pointer outside pool")
    `SSA_IMPLY(a_fail_zero, i_clk, i_rst_n, r_out_valid && r_out.status != ST_OK, r_out.stack_top_out == '0, "failed result carries an address")

endmodule

[rtl/stack_slot_allocator.sv]
// A word accepted by the front is written into the job queue, popped into the back-end job
// register when the back end is idle, then executed: a free or an unmatched address in a single
// step, an allocate in 1..POOL_SIZE probes, the back end probing one used bit per cycle while no
// result waits. A two-word job queue lets the front accept while the back end scans or a result waits.
// Reset (i_rst_n low, synchronous): every slot free, pointer at slot 0, pool_base 0.
// No clearing pass: the used bits are flip-flops cleared at once; the queue starts empty.
module stack_slot_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  ssa_pkg::t_in_word          i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ssa_pkg::t_out_word         o_out,
    input  logic                       i_cfg_we,
    input  logic [ssa_pkg::ADDR_W-1:0] i_cfg_wdata
);
    import ssa_pkg::*;

    // Pool base register; the user must write it only while the block is idle (the block itself does
    // not enforce this), so both the address decode and the top computation may read it directly.
    logic [ADDR_W-1:0] r_pool_base;

    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  pop;
    t_job  push_job;
    t_job  q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else if (i_cfg_we) begin
            r_pool_base <= i_cfg_wdata;
        end
    end

    // Front: decode the request word into an allocate, free or bad job.
    ssa_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .i_pool_base (r_pool_base),
        .i_full      (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Queue: decouple acceptance from execution.
    ssa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // Back: run the next-fit scan, clear the slot or report a bad address, then hold the result
    // word in the output register until it is taken.
    ssa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_base (r_pool_base),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule
